// ===== hdl/rta_pkg.sv =====
`default_nettype none
package rta_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [7:0] KIND_RAM = 8'd1;
  localparam logic [7:0] KIND_RESERVED = 8'd2;
  localparam logic [32:0] ADDR_SPACE_TOP = 33'h1_0000_0000;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_ZERO = 3'd1;
  localparam logic [2:0] ST_LIMIT = 3'd2;
  localparam logic [2:0] ST_NOFIT = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_EVAL,
    CELL_SPLIT,
    CELL_RETYPE
  } cell_op_t;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] length;
    logic [7:0]  kind;
  } entry_t;

  typedef struct packed {
    cell_op_t         op;
    entry_t           ent;
    logic [31:0]      size;
    logic [31:0]      mask;
    logic [32:0]      lim;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] sel;
    logic [31:0]      addr;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic stop;
    logic eq;
  } flags_t;
endpackage
`default_nettype wire

// ===== hdl/rta_cell.sv =====
`default_nettype none
module rta_cell (
  input  wire logic                 clk,
  input  wire logic [rta_pkg::IDX_W-1:0] idx,
  input  wire rta_pkg::cmd_t        cmd,
  input  wire rta_pkg::entry_t      prev_ent,
  input  wire logic                 prev_gt,
  output rta_pkg::entry_t           ent,
  output logic                      gt,
  output rta_pkg::flags_t           flags,
  output logic [31:0]               addr
);
  import rta_pkg::*;

  logic        valid;
  logic [64:0] top_sum;
  logic [63:0] cand_a;
  logic        cand;
  logic        hit;
  logic        at_count;
  logic        above_sel;
  logic        next_sel;
  logic [64:0] lower_end;

  assign valid = CNT_W'(idx) < cmd.count;
  assign at_count = CNT_W'(idx) == cmd.count;
  assign gt = valid && (ent.start > cmd.ent.start);
  assign top_sum = {1'b0, ent.start} + {1'b0, ent.length};
  assign cand = valid && (top_sum <= {32'd0, cmd.lim}) && (ent.kind == KIND_RAM)
                && (ent.length >= {32'd0, cmd.size});
  assign cand_a = (top_sum[63:0] - {32'd0, cmd.size}) & {32'd0, cmd.mask};
  assign hit = cand && (cand_a >= ent.start);
  assign above_sel = (IDX_W+1)'(idx) > (IDX_W+1)'(cmd.sel) + (IDX_W+1)'(1);
  assign next_sel = (IDX_W+1)'(idx) == (IDX_W+1)'(cmd.sel) + (IDX_W+1)'(1);
  assign lower_end = {1'b0, prev_ent.start} + {1'b0, prev_ent.length};

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_LOAD: begin
        if (prev_gt) begin
          ent <= prev_ent;
        end else if (gt || at_count) begin
          ent <= cmd.ent;
        end
      end
      CELL_EVAL: begin
        flags.hit <= hit;
        flags.stop <= cand && !hit && (ent.start == 64'd0);
        flags.eq <= cand_a == ent.start;
        addr <= cand_a[31:0];
      end
      CELL_SPLIT: begin
        if (above_sel && (valid || at_count)) begin
          ent <= prev_ent;
        end else if (next_sel) begin
          ent.start <= {32'd0, cmd.addr};
          ent.length <= lower_end[63:0] - {32'd0, cmd.addr};
          ent.kind <= KIND_RESERVED;
        end else if (idx == cmd.sel) begin
          ent.length <= {32'd0, cmd.addr} - ent.start;
          ent.kind <= KIND_RAM;
        end
      end
      CELL_RETYPE: begin
        if (idx == cmd.sel) begin
          ent.kind <= KIND_RESERVED;
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/range_table_allocator.sv =====
// request path: a request settled on arrival (zero-length load, full table, zero size,
// limit below size, empty table) goes straight to the result, a load passes through the
// cell load step, and an allocation passes through the cell evaluation, the downward
// walk over the cell flags, one entry per cycle, and the apply step
// throughput: one request at a time; a new request is taken while a result waits
// reset: synchronous, clears the entry count and handshake state; cells stay undefined
`default_nettype none
module range_table_allocator (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [231:0]  s_tdata,  // range_start, range_length, range_kind,
                                       // request_size, request_align, request_limit
  input  wire logic          s_tuser,  // opcode
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [39:0]        m_tdata   // granted_address, status, zero fill
);
  import rta_pkg::*;

  typedef enum logic [2:0] {IDLE, LOAD, EVAL, WALK, APPLY, DONE} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] ptr;
  entry_t           req_ent;
  logic [31:0]      req_size;
  logic [31:0]      req_mask;
  logic [32:0]      req_lim;
  logic [31:0]      res_addr;
  logic [2:0]       res_status;
  cmd_t             cmd;
  logic             accept;
  logic [32:0]      in_lim;

  entry_t ents  [TABLE_DEPTH];
  logic   gts   [TABLE_DEPTH];
  flags_t flg   [TABLE_DEPTH];
  logic [31:0] addrs [TABLE_DEPTH];

  assign s_tready = state == IDLE;
  assign accept = s_tvalid && s_tready;
  assign in_lim = (s_tdata[231:200] == 32'd0) ? ADDR_SPACE_TOP : {1'b0, s_tdata[231:200]};

  always_comb begin
    cmd.op = CELL_HOLD;
    cmd.ent = req_ent;
    cmd.size = req_size;
    cmd.mask = req_mask;
    cmd.lim = req_lim;
    cmd.count = count;
    cmd.sel = ptr;
    cmd.addr = addrs[ptr];
    case (state)
      LOAD: cmd.op = CELL_LOAD;
      EVAL: cmd.op = CELL_EVAL;
      APPLY: begin
        if (flg[ptr].eq) begin
          cmd.op = CELL_RETYPE;
        end else if (count < CNT_W'(TABLE_DEPTH)) begin
          cmd.op = CELL_SPLIT;
        end
      end
      default: cmd.op = CELL_HOLD;
    endcase
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      rta_cell u_cell (
        .clk(clk), .idx(IDX_W'(g)), .cmd(cmd), .prev_ent('0), .prev_gt(1'b0),
        .ent(ents[g]), .gt(gts[g]), .flags(flg[g]), .addr(addrs[g])
      );
    end else begin : g_rest
      rta_cell u_cell (
        .clk(clk), .idx(IDX_W'(g)), .cmd(cmd), .prev_ent(ents[g-1]), .prev_gt(gts[g-1]),
        .ent(ents[g]), .gt(gts[g]), .flags(flg[g]), .addr(addrs[g])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            req_ent.start <= s_tdata[63:0];
            req_ent.length <= s_tdata[127:64];
            req_ent.kind <= s_tdata[135:128];
            req_size <= s_tdata[167:136];
            req_mask <= 32'd0 - s_tdata[199:168];
            req_lim <= in_lim;
            ptr <= IDX_W'(count - CNT_W'(1));
            res_addr <= 32'd0;
            if (!s_tuser) begin
              if (s_tdata[127:64] == 64'd0) begin
                res_status <= ST_OK;
                state <= DONE;
              end else if (count >= CNT_W'(TABLE_DEPTH)) begin
                res_status <= ST_FULL;
                state <= DONE;
              end else begin
                res_status <= ST_OK;
                state <= LOAD;
              end
            end else if (s_tdata[167:136] == 32'd0) begin
              res_status <= ST_ZERO;
              state <= DONE;
            end else if (in_lim < {1'b0, s_tdata[167:136]}) begin
              res_status <= ST_LIMIT;
              state <= DONE;
            end else if (count == '0) begin
              res_status <= ST_NOFIT;
              state <= DONE;
            end else begin
              res_status <= ST_OK;
              state <= EVAL;
            end
          end
        end
        LOAD: begin
          count <= count + CNT_W'(1);
          state <= DONE;
        end
        EVAL: state <= WALK;
        WALK: begin
          if (flg[ptr].hit) begin
            state <= APPLY;
          end else if (flg[ptr].stop || ptr == '0) begin
            res_status <= ST_NOFIT;
            state <= DONE;
          end else begin
            ptr <= ptr - IDX_W'(1);
          end
        end
        APPLY: begin
          if (flg[ptr].eq) begin
            res_addr <= addrs[ptr];
          end else if (count < CNT_W'(TABLE_DEPTH)) begin
            res_addr <= addrs[ptr];
            count <= count + CNT_W'(1);
          end else begin
            res_status <= ST_FULL;
          end
          state <= DONE;
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {5'd0, res_status, res_addr};
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + CNT_W'(1)))
    else $error("entry count moved by more than one");
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[34:32] != ST_OK) |-> (m_tdata[31:0] == 32'd0))
    else $error("address given with error status");
  a_grow_busy: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> ($past(state) == LOAD || $past(state) == APPLY))
    else $error("entry count changed outside an insert");
endmodule
`default_nettype wire
